FILE: rtl/rlee_pkg.sv
`timescale 1ns / 1ps
// Package for the RGB LED effect engine: register indexes, effect mode codes,
// duty scaling constants and reciprocal constants for the shared multiplier.
// No dependencies.
package rlee_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_EFFECT_MODE    = 3'd0;
    localparam logic [2:0] REG_POWER_ENABLE   = 3'd1;
    localparam logic [2:0] REG_RED_LEVEL      = 3'd2;
    localparam logic [2:0] REG_GREEN_LEVEL    = 3'd3;
    localparam logic [2:0] REG_BLUE_LEVEL     = 3'd4;
    localparam logic [2:0] REG_BRIGHTNESS_PCT = 3'd5;

    // Effect modes
    typedef enum logic [1:0] {
        MODE_STATIC    = 2'd0,
        MODE_RAINBOW   = 2'd1,
        MODE_BREATHING = 2'd2,
        MODE_BLINK     = 2'd3
    } effect_mode_t;

    // Shared multiplier geometry
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Full-scale PWM duty (1023) and duty field limit
    localparam logic [MUL_B_W-1:0] DUTY_MAX   = 25'd1023;
    localparam int                 DUTY_W     = 10;
    localparam logic [16:0]        DUTY_LIMIT = 17'd1023;

    // Reciprocals, rounded up; exact quotients over the operand ranges used:
    //   hue / 60   for hue < 1490
    //   p / 100    for p < 43690  (p <= 255 * 100)
    //   y / 255    for y < 16.9M  (y <= 255 * 1023)
    localparam logic [MUL_B_W-1:0] RECIP_60   = 25'd1093;
    localparam int                 SHIFT_60   = 16;
    localparam logic [MUL_B_W-1:0] RECIP_100  = 25'd5243;
    localparam int                 SHIFT_100  = 19;
    localparam logic [MUL_B_W-1:0] RECIP_255  = 25'd16843010;
    localparam int                 SHIFT_255  = 32;

    // Level limits
    localparam logic [6:0] LEVEL_FULL   = 7'd100;
    localparam logic [6:0] BREATH_FLOOR = 7'd10;
    localparam logic [8:0] HUE_WRAP     = 9'd360;

endpackage

FILE: rtl/rgb_led_effect_engine_unit.sv
`timescale 1ns / 1ps
// RGB LED effect engine: static, rainbow, breathing and blink effects turned
// into three PWM duties by one shared multiplier under a small sequencer.
// Depends on rlee_pkg.
//
//  channel   | signals                         | beat contents (low bit up)
//  ----------+---------------------------------+-------------------------------
//  input     | s_axis_tvalid/tready/tdata[7:0] | advance, 7 zero bits
//  output    | m_axis_tvalid/tready/tdata[31:0]| duty_red, duty_green,
//            |                                 | duty_blue, 2 zero bits
//  config    | cfg_we, cfg_index, cfg_data     | register index, write data
//
// A beat with advance = 0 goes from accept through ST_OUT to the result register.
// An advancing beat runs four passes through the multiplier and a store per color
// channel, after the ST_HUE and ST_COLOR hue-to-color steps in rainbow mode.
// Input is taken only in the idle state; a result held by a stalled output
// waits in the output register. Reset sets all state at once, no sweep.
module rgb_led_effect_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] advance, [7:1] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [9:0] duty_red, [19:10] duty_green,
                                        // [29:20] duty_blue, [31:30] zero
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import rlee_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HUE,
        ST_COLOR,
        ST_CL,
        ST_DIV100,
        ST_DUTY,
        ST_DIV255,
        ST_STORE,
        ST_OUT
    } state_t;

    state_t             state_reg;
    effect_mode_t       mode_reg;
    logic               power_reg;
    logic [7:0]         red_reg;
    logic [7:0]         green_reg;
    logic [7:0]         blue_reg;
    logic [6:0]         bright_reg;

    logic [8:0]         hue_reg;
    logic [6:0]         breath_reg;
    logic               rising_reg;
    logic               blink_on_reg;

    logic [7:0]         color_reg [3];
    logic [6:0]         lvl_reg;
    logic [1:0]         chan_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [DUTY_W-1:0]  held_reg [3];
    logic               out_valid_reg;
    logic [31:0]        out_data_reg;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod_next;

    logic [6:0]         bright_sat;
    logic               in_beat;
    logic               out_free;

    // hue to color
    logic [3:0]         hue_q;
    logic [8:0]         hue_q60;
    logic [5:0]         hue_rem;
    logic [5:0]         hue_inv;
    logic [2:0]         sext;
    logic [9:0]         up_x17;
    logic [9:0]         down_x17;
    logic [7:0]         up_val;
    logic [7:0]         down_val;

    // duty finish
    logic [16:0]        duty_raw;
    logic [DUTY_W-1:0]  duty_val;

    // effect state step
    logic [7:0]         breath_step;
    logic [6:0]         breath_next;
    logic               rising_next;
    logic [9:0]         hue_plus;
    logic [8:0]         hue_next;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign bright_sat = (bright_reg > LEVEL_FULL) ? LEVEL_FULL : bright_reg;

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_HUE:
            begin
                mul_a = MUL_A_W'(hue_reg);
                mul_b = RECIP_60;
            end
            ST_CL:
            begin
                mul_a = MUL_A_W'(color_reg[chan_reg]);
                mul_b = MUL_B_W'(lvl_reg);
            end
            ST_DIV100:
            begin
                mul_a = MUL_A_W'(prod_reg[14:0]);
                mul_b = RECIP_100;
            end
            ST_DUTY:
            begin
                mul_a = MUL_A_W'(prod_reg[SHIFT_100 +: 8]);
                mul_b = DUTY_MAX;
            end
            ST_DIV255:
            begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = RECIP_255;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Sextant and position inside it; 255/60 reduces to 17/4
    assign hue_q    = prod_reg[SHIFT_60 +: 4];
    assign hue_q60  = (9'(hue_q) << 6) - (9'(hue_q) << 2);
    assign hue_rem  = 6'(hue_reg - hue_q60);
    assign hue_inv  = 6'd60 - hue_rem;
    assign sext     = (hue_q >= 4'd6) ? 3'(hue_q - 4'd6) : hue_q[2:0];
    assign up_x17   = (10'(hue_rem) << 4) + 10'(hue_rem);
    assign down_x17 = (10'(hue_inv) << 4) + 10'(hue_inv);
    assign up_val   = up_x17[9:2];
    assign down_val = down_x17[9:2];

    // Duty saturation and power gating
    assign duty_raw = prod_reg[SHIFT_255 +: 17];
    always_comb
    begin
        if (!power_reg)
            duty_val = '0;
        else if (duty_raw > DUTY_LIMIT)
            duty_val = DUTY_LIMIT[DUTY_W-1:0];
        else
            duty_val = duty_raw[DUTY_W-1:0];
    end

    // Breathing ramp and hue step
    always_comb
    begin
        if (rising_reg)
            breath_step = 8'(breath_reg) + 8'd2;
        else if (breath_reg >= 7'd2)
            breath_step = 8'(breath_reg) - 8'd2;
        else
            breath_step = 8'd0;

        if (breath_step >= 8'(LEVEL_FULL))
        begin
            breath_next = LEVEL_FULL;
            rising_next = 1'b0;
        end
        else if (breath_step <= 8'(BREATH_FLOOR))
        begin
            breath_next = BREATH_FLOOR;
            rising_next = 1'b1;
        end
        else
        begin
            breath_next = breath_step[6:0];
            rising_next = rising_reg;
        end

        hue_plus = 10'(hue_reg) + 10'd2;
        if (hue_plus >= 10'(HUE_WRAP))
            hue_next = 9'(hue_plus - 10'(HUE_WRAP));
        else
            hue_next = hue_plus[8:0];
    end

    // Sequencer, effect state, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_STATIC;
            power_reg     <= 1'b1;
            red_reg       <= 8'd255;
            green_reg     <= 8'd255;
            blue_reg      <= 8'd255;
            bright_reg    <= 7'd50;
            hue_reg       <= '0;
            breath_reg    <= BREATH_FLOOR;
            rising_reg    <= 1'b1;
            blink_on_reg  <= 1'b0;
            color_reg[0]  <= '0;
            color_reg[1]  <= '0;
            color_reg[2]  <= '0;
            lvl_reg       <= '0;
            chan_reg      <= '0;
            prod_reg      <= '0;
            held_reg[0]   <= '0;
            held_reg[1]   <= '0;
            held_reg[2]   <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // taken result leaves, unless a new one is loaded below
            if (out_valid_reg && m_axis_tready && (state_reg != ST_OUT))
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat)
                    begin
                        chan_reg     <= '0;
                        color_reg[0] <= red_reg;
                        color_reg[1] <= green_reg;
                        color_reg[2] <= blue_reg;
                        lvl_reg      <= bright_sat;
                        if (!s_axis_tdata[0])
                            state_reg <= ST_OUT;
                        else
                        begin
                            case (mode_reg)
                                MODE_RAINBOW:   state_reg <= ST_HUE;
                                MODE_BREATHING:
                                begin
                                    lvl_reg   <= breath_reg;
                                    state_reg <= ST_CL;
                                end
                                MODE_BLINK:
                                begin
                                    // off phase shows black
                                    if (!blink_on_reg)
                                    begin
                                        color_reg[0] <= '0;
                                        color_reg[1] <= '0;
                                        color_reg[2] <= '0;
                                        lvl_reg      <= '0;
                                    end
                                    state_reg <= ST_CL;
                                end
                                default:        state_reg <= ST_CL;
                            endcase
                        end
                    end
                end
                ST_HUE:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_COLOR;
                end
                ST_COLOR:
                begin
                    case (sext)
                        3'd0:
                        begin
                            color_reg[0] <= 8'd255;
                            color_reg[1] <= up_val;
                            color_reg[2] <= 8'd0;
                        end
                        3'd1:
                        begin
                            color_reg[0] <= down_val;
                            color_reg[1] <= 8'd255;
                            color_reg[2] <= 8'd0;
                        end
                        3'd2:
                        begin
                            color_reg[0] <= 8'd0;
                            color_reg[1] <= 8'd255;
                            color_reg[2] <= up_val;
                        end
                        3'd3:
                        begin
                            color_reg[0] <= 8'd0;
                            color_reg[1] <= down_val;
                            color_reg[2] <= 8'd255;
                        end
                        3'd4:
                        begin
                            color_reg[0] <= up_val;
                            color_reg[1] <= 8'd0;
                            color_reg[2] <= 8'd255;
                        end
                        default:
                        begin
                            color_reg[0] <= 8'd255;
                            color_reg[1] <= 8'd0;
                            color_reg[2] <= down_val;
                        end
                    endcase
                    state_reg <= ST_CL;
                end
                ST_CL:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_DIV100;
                end
                ST_DIV100:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_DUTY;
                end
                ST_DUTY:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_DIV255;
                end
                ST_DIV255:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_STORE;
                end
                ST_STORE:
                begin
                    held_reg[chan_reg] <= duty_val;
                    if (chan_reg == 2'd2)
                    begin
                        // last channel done: step the effect
                        case (mode_reg)
                            MODE_RAINBOW:   hue_reg <= hue_next;
                            MODE_BREATHING:
                            begin
                                breath_reg <= breath_next;
                                rising_reg <= rising_next;
                            end
                            MODE_BLINK:     blink_on_reg <= !blink_on_reg;
                            default:        ;
                        endcase
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        chan_reg  <= chan_reg + 2'd1;
                        state_reg <= ST_CL;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {2'b00, held_reg[2], held_reg[1], held_reg[0]};
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            // Register writes; a mode write restarts hue and breathing
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_EFFECT_MODE:
                    begin
                        mode_reg   <= effect_mode_t'(cfg_data[1:0]);
                        hue_reg    <= '0;
                        breath_reg <= BREATH_FLOOR;
                        rising_reg <= 1'b1;
                    end
                    REG_POWER_ENABLE:   power_reg  <= cfg_data[0];
                    REG_RED_LEVEL:      red_reg    <= cfg_data;
                    REG_GREEN_LEVEL:    green_reg  <= cfg_data;
                    REG_BLUE_LEVEL:     blue_reg   <= cfg_data;
                    REG_BRIGHTNESS_PCT: bright_reg <= cfg_data[6:0];
                    default:            ;
                endcase
            end
        end
    end

endmodule

FILE: rtl/rlee_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the RGB LED effect engine, bound to the top level.
// Depends on rgb_led_effect_engine_unit port names only.
module rlee_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // one beat in flight: input closes right after a beat is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input still ready after accepted beat");

    // a new result only appears at the end of work, while input was closed
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a beat in work");

    // stalled result stays offered
    a_out_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    // stalled result holds its duties
    a_out_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

endmodule

bind rgb_led_effect_engine_unit rlee_checker u_rlee_checker (.*);

FILE: dv/tb_rgb_led_effect_engine_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for rgb_led_effect_engine_unit: drives tick beats and
// register writes, predicts the three held PWM duties per beat and compares them.
// Depends on rlee_pkg and the rgb_led_effect_engine_unit RTL.
module tb_rgb_led_effect_engine_unit;
    import rlee_pkg::*;

    localparam int QUIET_LIMIT = 4000;  // cycles with no beat on either side
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off

    // Duty predictor and store of expected duty triples
    class duty_scoreboard;
        effect_mode_t mode;
        bit           pwr_en;
        bit [7:0]     base_r, base_g, base_b;
        bit [6:0]     bright;
        int           hue, breath;
        bit           rising, blink_on;
        bit [9:0]     held_r, held_g, held_b;
        bit [29:0]    duty_q[$];        // {blue, green, red}
        int           errors;
        int           compared;

        function new();
            errors   = 0;
            compared = 0;
            mode     = MODE_STATIC;
            pwr_en   = 1'b1;
            base_r   = 8'd255;
            base_g   = 8'd255;
            base_b   = 8'd255;
            bright   = 7'd50;
            restart();
            blink_on = 1'b0;
            held_r   = '0;
            held_g   = '0;
            held_b   = '0;
        endfunction

        function void restart();
            hue    = 0;
            breath = 10;
            rising = 1'b1;
        endfunction

        // Mirror of a register write; indexes past the last one are ignored
        function void write_reg(logic [2:0] idx, logic [7:0] val);
            case (idx)
                REG_EFFECT_MODE:
                begin
                    mode = effect_mode_t'(val[1:0]);
                    restart();
                end
                REG_POWER_ENABLE:   pwr_en   = val[0];
                REG_RED_LEVEL:      base_r   = val;
                REG_GREEN_LEVEL:    base_g   = val;
                REG_BLUE_LEVEL:     base_b   = val;
                REG_BRIGHTNESS_PCT: bright   = val[6:0];
                default: ;
            endcase
        endfunction

        // Channel to duty: percent scale, then to full-scale duty
        function bit [9:0] scale(int c, int lvl);
            int x;
            int d;
            if (!pwr_en)
                return '0;
            if (lvl > 100)
                lvl = 100;
            x = (c * lvl) / 100;
            d = (x * int'(DUTY_MAX)) / 255;
            if (d > 1023)
                d = 1023;
            return d[9:0];
        endfunction

        function void show(int r, int g, int b, int lvl);
            held_r = scale(r, lvl);
            held_g = scale(g, lvl);
            held_b = scale(b, lvl);
        endfunction

        // One effect tick
        function void advance_step();
            int sext;
            int rem;
            int up;
            int down;
            int r;
            int g;
            int b;
            case (mode)
                MODE_STATIC: show(base_r, base_g, base_b, bright);
                MODE_RAINBOW:
                begin
                    sext = (hue / 60) % 6;
                    rem  = hue % 60;
                    up   = (255 * rem) / 60;
                    down = (255 * (60 - rem)) / 60;
                    case (sext)
                        0: begin r = 255;  g = up;   b = 0;    end
                        1: begin r = down; g = 255;  b = 0;    end
                        2: begin r = 0;    g = 255;  b = up;   end
                        3: begin r = 0;    g = down; b = 255;  end
                        4: begin r = up;   g = 0;    b = 255;  end
                        default: begin r = 255; g = 0; b = down; end
                    endcase
                    show(r, g, b, bright);
                    hue = (hue + 2) % 360;
                end
                MODE_BREATHING:
                begin
                    show(base_r, base_g, base_b, breath);
                    if (rising)
                        breath = breath + 2;
                    else
                        breath = (breath >= 2) ? breath - 2 : 0;
                    if (breath >= 100)
                    begin
                        breath = 100;
                        rising = 1'b0;
                    end
                    else if (breath <= 10)
                    begin
                        breath = 10;
                        rising = 1'b1;
                    end
                end
                default:
                begin
                    if (blink_on)
                        show(base_r, base_g, base_b, bright);
                    else
                        show(0, 0, 0, 0);
                    blink_on = ~blink_on;
                end
            endcase
        endfunction

        // Accepted tick beat: every beat reports the held duties
        function void note_input(bit adv);
            if (adv)
                advance_step();
            duty_q.push_back({held_b, held_g, held_r});
        endfunction

        function void field_check(string name, logic [9:0] want, logic [9:0] got);
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch %s: expected %0d, got %0d (result %0d)",
                             name, want, got, compared);
            end
        endfunction

        // Accepted result beat against the oldest expectation
        function void check_result(logic [31:0] data);
            bit [29:0] want;
            if (duty_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat %h", data);
                return;
            end
            want = duty_q.pop_front();
            field_check("duty_red",   want[9:0],   data[9:0]);
            field_check("duty_green", want[19:10], data[19:10]);
            field_check("duty_blue",  want[29:20], data[29:20]);
            compared++;
        endfunction

        function int pending();
            return duty_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;

    duty_scoreboard sb;
    bit  calm;           // no random gaps on either side
    bit  hold_off_req;   // ask the receiver for one long hold-off
    int  beats;
    int  adv_beats;
    int  settings;
    int  quiet;

    rgb_led_effect_engine_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 19) < 16)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Monitor: compare results, note accepted ticks, watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
            begin
                sb.note_input(s_axis_tdata[0]);
                beats++;
                if (s_axis_tdata[0])
                    adv_beats++;
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Receiver: random back-pressure plus one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap_len()) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // One tick beat, held until accepted
    task automatic send_beat(bit adv);
        int gap;
        gap = (calm || $urandom_range(0, 2) != 0) ? 0 : gap_len();
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, adv};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Stop sending and wait for every expected result
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] pick_color();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_bright();
        case ($urandom_range(0, 4))
            0:       return 8'd0;
            1:       return 8'd100;
            2:       return 8'($urandom_range(101, 127)) | 8'($urandom_range(0, 1) << 7);
            default: return 8'($urandom_range(0, 100));
        endcase
    endfunction

    // New random setting; upper data bits are random to exercise masking
    task automatic random_setting();
        if ($urandom_range(0, 9) < 6)
            write_reg(REG_EFFECT_MODE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_POWER_ENABLE, 8'($urandom_range(0, 255)));
        else if ($urandom_range(0, 1) == 0)
            write_reg(REG_POWER_ENABLE, 8'd1);
        if ($urandom_range(0, 1) == 0)
            write_reg(REG_RED_LEVEL, pick_color());
        if ($urandom_range(0, 1) == 0)
            write_reg(REG_GREEN_LEVEL, pick_color());
        if ($urandom_range(0, 1) == 0)
            write_reg(REG_BLUE_LEVEL, pick_color());
        if ($urandom_range(0, 1) == 0)
            write_reg(REG_BRIGHTNESS_PCT, pick_bright());
        if ($urandom_range(0, 7) == 0)
            write_reg(3'($urandom_range(6, 7)), 8'($urandom_range(0, 255)));
        settings++;
    endtask

    task automatic run_beats(int n, int adv_pct);
        for (int i = 0; i < n; i++)
            send_beat($urandom_range(0, 99) < adv_pct);
    endtask

    // Main sequence
    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        calm          = 1'b0;
        hold_off_req  = 1'b0;
        beats         = 0;
        adv_beats     = 0;
        settings      = 0;
        quiet         = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: held duties after reset, then static at reset color
        send_beat(1'b0);
        send_beat(1'b1);
        drain();
        // Full brightness; a write alone leaves the held duties alone
        write_reg(REG_BRIGHTNESS_PCT, 8'd100);
        send_beat(1'b0);
        send_beat(1'b1);
        drain();
        write_reg(REG_RED_LEVEL, 8'd0);
        write_reg(REG_GREEN_LEVEL, 8'd1);
        write_reg(REG_BLUE_LEVEL, 8'd255);
        send_beat(1'b1);
        drain();
        write_reg(REG_BRIGHTNESS_PCT, 8'd0);
        send_beat(1'b1);
        drain();
        // Brightness above hundred saturates; bit 7 of the data is dropped
        write_reg(REG_BRIGHTNESS_PCT, 8'hFF);
        send_beat(1'b1);
        drain();
        write_reg(REG_BRIGHTNESS_PCT, 8'd101);
        send_beat(1'b1);
        drain();
        // Power off forces zero duties
        write_reg(REG_POWER_ENABLE, 8'hFE);
        send_beat(1'b1);
        send_beat(1'b0);
        drain();
        // Power back on; writes to unknown indexes change nothing
        write_reg(REG_POWER_ENABLE, 8'h01);
        write_reg(3'd6, 8'hAA);
        write_reg(3'd7, 8'h55);
        send_beat(1'b1);
        drain();
        // Blink, then a same-mode write that keeps the blink phase
        write_reg(REG_EFFECT_MODE, 8'hFF);
        send_beat(1'b1);
        send_beat(1'b1);
        send_beat(1'b1);
        drain();
        write_reg(REG_EFFECT_MODE, 8'h07);
        send_beat(1'b1);
        drain();
        // Rainbow, then a rewrite of the same mode restarts the hue
        write_reg(REG_EFFECT_MODE, 8'h01);
        send_beat(1'b1);
        send_beat(1'b1);
        send_beat(1'b1);
        drain();
        write_reg(REG_EFFECT_MODE, 8'h05);
        send_beat(1'b1);
        drain();
        // Breathing and back to static
        write_reg(REG_EFFECT_MODE, 8'(MODE_BREATHING));
        send_beat(1'b1);
        send_beat(1'b1);
        send_beat(1'b1);
        drain();
        write_reg(REG_EFFECT_MODE, 8'(MODE_STATIC));
        send_beat(1'b0);
        send_beat(1'b1);
        drain();
        settings++;

        // Long receiver hold-off while the sender keeps offering beats
        calm = 1'b1;
        random_setting();
        hold_off_req = 1'b1;
        run_beats(40, 75);
        drain();
        calm = 1'b0;

        // Rainbow over more than a full hue turn
        write_reg(REG_EFFECT_MODE, 8'(MODE_RAINBOW));
        write_reg(REG_BRIGHTNESS_PCT, 8'd100);
        settings++;
        run_beats(220, 95);
        drain();

        // Breathing through a full ramp up and down
        write_reg(REG_EFFECT_MODE, 8'(MODE_BREATHING));
        write_reg(REG_RED_LEVEL, 8'd255);
        settings++;
        run_beats(110, 92);
        drain();

        // Random settings, idling switched on and off per phase
        for (int p = 0; p < 10; p++)
        begin
            calm = ($urandom_range(0, 3) == 0);
            random_setting();
            run_beats(50, 75);
            drain();
        end
        calm = 1'b0;

        repeat (20) @(posedge clk);
        if (sb.pending() != 0)
        begin
            sb.errors += sb.pending();
            $display("%0d expected results never arrived", sb.pending());
        end
        $display("Ran %0d tick beats (%0d advancing) over %0d register settings,",
                 beats, adv_beats, settings);
        $display("all four effect modes; %0d duty triples compared, %0d mismatches.",
                 sb.compared, sb.errors);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
